// ----- src/fcr_pkg.sv -----
package fcr_pkg;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] SKIP_BYTE  = 8'hFF;
	localparam logic [7:0] STOP_BYTE  = 8'h03;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_ONE  = 8'h31;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam int unsigned BITS_PER_BYTE = 8;

	localparam logic [7:0] OWN_ADDRESS_RESET = 8'd76;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_STOP   = 2'd2;

	// Depth of the event queue between the parser and the response sequencer.
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [3:0] {
		PH_HUNT = 4'd0,
		PH_LEN  = 4'd1,
		PH_ADDR = 4'd2,
		PH_CMD  = 4'd3,
		PH_ARGS = 4'd4,
		PH_CSUM = 4'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_STOP     = 3'd1,
		EV_ACK_ONE  = 3'd2,
		EV_ACK_ZERO = 3'd3,
		EV_ACCEPT   = 3'd4
	} event_t;

	typedef struct packed {
		event_t      ev;
		logic [23:0] command;
	} entry_t;

	typedef struct packed {
		logic        push;
		entry_t      entry;
	} push_t;

	typedef struct packed {
		logic        full;
		logic        empty;
		entry_t      head;
	} queue_status_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  tx_byte;
		logic [23:0] frame_command;
		logic        last_of_run;
	} result_t;

	function automatic logic [3:0] ones_in(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < BITS_PER_BYTE; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

endpackage

// ----- src/fcr_byte_if.sv -----
interface fcr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/fcr_result_if.sv -----
interface fcr_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [7:0]  tx_byte;
	logic [23:0] frame_command;
	logic        last_of_run;

	modport source (output valid, output out_kind, output tx_byte, output frame_command,
		output last_of_run, input ready);
	modport sink (input valid, input out_kind, input tx_byte, input frame_command,
		input last_of_run, output ready);
endinterface

// ----- src/framed_command_receiver_unit.sv -----
// Frame receiver for a byte stream: a parser takes one received word per clock whenever its
// two-entry event queue has room, and a response sequencer behind the queue sends one result
// word per clock, while the result side is ready, from a registered output. A byte that
// closes or aborts a frame yields three words (an acknowledge) or seven words (acknowledge
// twice, then the accepted command), a stop byte between frames one stop word, so the
// sustained rate is set by the sequencer. own_address (reset 76) should be written only while idle.
module framed_command_receiver_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [7:0]    wr_data,
	fcr_byte_if.sink      rx,
	fcr_result_if.source  result
);

	logic [7:0]             own_address_q;
	fcr_pkg::push_t         qpush;
	fcr_pkg::queue_status_t qstat;
	logic                   pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= fcr_pkg::OWN_ADDRESS_RESET;
		end else if (wr_en) begin
			own_address_q <= wr_data;
		end
	end

	fcr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_address (own_address_q),
		.rx          (rx),
		.qstat       (qstat),
		.qpush       (qpush)
	);

	fcr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.pop    (pop),
		.qstat  (qstat)
	);

	fcr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

	// The parser only raises an event on a byte it took, and it takes none while the queue is full.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(qpush.push && qstat.full))
		else $error("event pushed into a full queue");

	// A stop or accepted word always ends its run.
	a_single_word_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.out_kind == fcr_pkg::KIND_STOP ||
		result.out_kind == fcr_pkg::KIND_ACCEPT) |-> result.last_of_run)
		else $error("stop or accepted word without end of run");

	// A transmit word closing a run carries an acknowledge digit.
	a_ack_digit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.out_kind == fcr_pkg::KIND_TX && result.last_of_run |->
		(result.tx_byte == fcr_pkg::ASCII_ONE || result.tx_byte == fcr_pkg::ASCII_ZERO))
		else $error("run ended on a transmit word that is not a digit");

	// Once a word is taken from the queue, the sequencer has output to show on the next edge.
	a_pop_gives_output: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result.valid)
		else $error("queue popped without an output word");

endmodule

// ----- src/fcr_front.sv -----
module fcr_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              own_address,
	fcr_byte_if.sink                rx,
	input  fcr_pkg::queue_status_t  qstat,
	output fcr_pkg::push_t          qpush
);

	fcr_pkg::phase_t phase_q, phase_d;
	logic [1:0]  digit_count_q, digit_count_d;
	logic        number_done_q, number_done_d;
	logic [6:0]  length_value_q, length_value_d;
	logic [6:0]  args_left_q, args_left_d;
	logic [9:0]  bit_sum_q, bit_sum_d;
	logic [9:0]  sent_sum_q, sent_sum_d;
	logic [23:0] command_hold_q, command_hold_d;

	logic        take;
	logic [7:0]  b;
	logic        is_digit;
	logic [7:0]  digit_val;
	logic [1:0]  count_inc;
	logic [9:0]  ones_ext;
	logic [9:0]  len_prod;
	logic [13:0] sum_prod;
	logic [6:0]  args_dec;
	fcr_pkg::event_t ev;

	assign rx.ready  = !qstat.full;
	assign b         = rx.rx_byte;
	assign take      = rx.valid && rx.ready && (b != fcr_pkg::SKIP_BYTE);
	assign is_digit  = (b >= fcr_pkg::ASCII_ZERO) && (b <= fcr_pkg::ASCII_NINE);
	assign digit_val = b - fcr_pkg::ASCII_ZERO;
	assign count_inc = digit_count_q + 2'd1;
	assign ones_ext  = 10'(fcr_pkg::ones_in(b));
	assign len_prod  = 10'(length_value_q) * 10'd10 + 10'(digit_val);
	assign sum_prod  = 14'(sent_sum_q) * 14'd10 + 14'(digit_val);
	assign args_dec  = (args_left_q != 7'd0) ? args_left_q - 7'd1 : args_left_q;

	// Next state of the frame parser.
	always_comb begin
		phase_d        = phase_q;
		digit_count_d  = digit_count_q;
		number_done_d  = number_done_q;
		length_value_d = length_value_q;
		args_left_d    = args_left_q;
		bit_sum_d      = bit_sum_q;
		sent_sum_d     = sent_sum_q;
		command_hold_d = command_hold_q;
		if (take) begin
			unique case (phase_q)
				fcr_pkg::PH_HUNT: begin
					if (b == fcr_pkg::START_BYTE) begin
						bit_sum_d      = '0;
						digit_count_d  = '0;
						number_done_d  = 1'b0;
						length_value_d = '0;
						phase_d        = fcr_pkg::PH_LEN;
					end
				end
				fcr_pkg::PH_LEN: begin
					if (!number_done_q) begin
						if (is_digit) begin
							length_value_d = len_prod[6:0];
						end else begin
							number_done_d = 1'b1;
						end
					end
					digit_count_d = count_inc;
					if (count_inc >= 2'd2) begin
						args_left_d = (length_value_d > 7'd4) ? length_value_d - 7'd4 : 7'd0;
						phase_d     = fcr_pkg::PH_ADDR;
					end
				end
				fcr_pkg::PH_ADDR: begin
					bit_sum_d = ones_ext;
					if (b != own_address) begin
						phase_d = fcr_pkg::PH_HUNT;
					end else begin
						digit_count_d  = '0;
						command_hold_d = '0;
						phase_d        = fcr_pkg::PH_CMD;
					end
				end
				fcr_pkg::PH_CMD: begin
					command_hold_d = {command_hold_q[15:0], b};
					bit_sum_d      = bit_sum_q + ones_ext;
					digit_count_d  = count_inc;
					if (count_inc == 2'd3) begin
						if (args_left_q != 7'd0) begin
							phase_d = fcr_pkg::PH_ARGS;
						end else begin
							digit_count_d = '0;
							number_done_d = 1'b0;
							sent_sum_d    = '0;
							phase_d       = fcr_pkg::PH_CSUM;
						end
					end
				end
				fcr_pkg::PH_ARGS: begin
					bit_sum_d   = bit_sum_q + ones_ext;
					args_left_d = args_dec;
					if (args_dec == 7'd0) begin
						digit_count_d = '0;
						number_done_d = 1'b0;
						sent_sum_d    = '0;
						phase_d       = fcr_pkg::PH_CSUM;
					end
				end
				fcr_pkg::PH_CSUM: begin
					if (!number_done_q) begin
						if (is_digit) begin
							sent_sum_d = sum_prod[9:0];
						end else begin
							number_done_d = 1'b1;
						end
					end
					digit_count_d = count_inc;
					if (count_inc == 2'd3) begin
						phase_d = fcr_pkg::PH_HUNT;
					end
				end
				default: begin
					phase_d = fcr_pkg::PH_HUNT;
				end
			endcase
		end
	end

	// Event handed to the response sequencer for this byte.
	always_comb begin
		ev = fcr_pkg::EV_NONE;
		if (take) begin
			unique case (phase_q)
				fcr_pkg::PH_HUNT: begin
					if (b == fcr_pkg::STOP_BYTE) begin
						ev = fcr_pkg::EV_STOP;
					end
				end
				fcr_pkg::PH_ADDR: begin
					if (b != own_address) begin
						ev = fcr_pkg::EV_ACK_ONE;
					end
				end
				fcr_pkg::PH_CSUM: begin
					if (count_inc == 2'd3) begin
						ev = (bit_sum_q == sent_sum_d) ? fcr_pkg::EV_ACCEPT
							: fcr_pkg::EV_ACK_ZERO;
					end
				end
				default: begin
					ev = fcr_pkg::EV_NONE;
				end
			endcase
		end
	end

	assign qpush.push          = (ev != fcr_pkg::EV_NONE);
	assign qpush.entry.ev      = ev;
	assign qpush.entry.command = command_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= fcr_pkg::PH_HUNT;
			digit_count_q  <= '0;
			number_done_q  <= 1'b0;
			length_value_q <= '0;
			args_left_q    <= '0;
			bit_sum_q      <= '0;
			sent_sum_q     <= '0;
			command_hold_q <= '0;
		end else begin
			phase_q        <= phase_d;
			digit_count_q  <= digit_count_d;
			number_done_q  <= number_done_d;
			length_value_q <= length_value_d;
			args_left_q    <= args_left_d;
			bit_sum_q      <= bit_sum_d;
			sent_sum_q     <= sent_sum_d;
			command_hold_q <= command_hold_d;
		end
	end

endmodule

// ----- src/fcr_queue.sv -----
module fcr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fcr_pkg::push_t          qpush,
	input  logic                    pop,
	output fcr_pkg::queue_status_t  qstat
);

	localparam int unsigned PtrW = (fcr_pkg::QUEUE_DEPTH > 1) ? $clog2(fcr_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(fcr_pkg::QUEUE_DEPTH + 1);
	localparam logic [CntW-1:0] Depth = CntW'(fcr_pkg::QUEUE_DEPTH);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(fcr_pkg::QUEUE_DEPTH - 1);

	fcr_pkg::entry_t store_q [fcr_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign qstat.full  = (count_q == Depth);
	assign qstat.empty = (count_q == '0);
	assign qstat.head  = store_q[rd_ptr_q];

	assign do_push = qpush.push && !qstat.full;
	assign do_pop  = pop && !qstat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= qpush.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ----- src/fcr_back.sv -----
module fcr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fcr_pkg::queue_status_t  qstat,
	output logic                    pop,
	fcr_result_if.source            result
);

	fcr_pkg::entry_t  cur_q;
	logic             busy_q;
	logic [2:0]       step_q;
	logic             out_valid_q;
	fcr_pkg::result_t out_q;

	fcr_pkg::entry_t  sel;
	logic [2:0]       step_now;
	logic             advance;
	logic             have_work;
	fcr_pkg::result_t word;

	assign advance   = !out_valid_q || result.ready;
	assign have_work = busy_q || !qstat.empty;
	assign sel       = busy_q ? cur_q : qstat.head;
	assign step_now  = busy_q ? step_q : 3'd0;
	assign pop       = advance && !busy_q && !qstat.empty;

	// Word number step_now of the response to the selected event.
	always_comb begin
		word = '0;
		unique case (sel.ev)
			fcr_pkg::EV_STOP: begin
				word.out_kind    = fcr_pkg::KIND_STOP;
				word.last_of_run = 1'b1;
			end
			fcr_pkg::EV_ACK_ONE, fcr_pkg::EV_ACK_ZERO: begin
				word.out_kind    = fcr_pkg::KIND_TX;
				word.last_of_run = (step_now == 3'd2);
				if (step_now == 3'd2) begin
					word.tx_byte = (sel.ev == fcr_pkg::EV_ACK_ONE) ? fcr_pkg::ASCII_ONE
						: fcr_pkg::ASCII_ZERO;
				end else begin
					word.tx_byte = fcr_pkg::START_BYTE;
				end
			end
			fcr_pkg::EV_ACCEPT: begin
				if (step_now == 3'd6) begin
					word.out_kind      = fcr_pkg::KIND_ACCEPT;
					word.frame_command = sel.command;
					word.last_of_run   = 1'b1;
				end else begin
					word.out_kind = fcr_pkg::KIND_TX;
					word.tx_byte  = (step_now == 3'd2 || step_now == 3'd5) ? fcr_pkg::ASCII_ONE
						: fcr_pkg::START_BYTE;
				end
			end
			default: begin
				word.last_of_run = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance && have_work) begin
			out_q <= word;
			cur_q <= sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= have_work;
			if (have_work) begin
				busy_q <= !word.last_of_run;
				step_q <= step_now + 3'd1;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_kind      = out_q.out_kind;
	assign result.tx_byte       = out_q.tx_byte;
	assign result.frame_command = out_q.frame_command;
	assign result.last_of_run   = out_q.last_of_run;

endmodule

// ----- tb/framed_command_receiver_unit_test.sv -----
`timescale 1ns / 1ps

module framed_command_receiver_unit_test;

	typedef logic [7:0] byte_seq_t [$];

	localparam int unsigned SETTLE_CYCLES = 32;
	localparam int unsigned RANDOM_WORDS = 360;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       wr_en;
	logic [7:0] wr_data;

	fcr_byte_if   rx ();
	fcr_result_if result ();

	framed_command_receiver_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_data(wr_data),
		.rx(rx),
		.result(result)
	);

	// Parser state mirrored at word granularity.
	fcr_pkg::phase_t parse_phase;
	logic [1:0]  char_count;
	logic        digits_closed;
	logic [6:0]  frame_length;
	logic [6:0]  args_remaining;
	logic [9:0]  ones_total;
	logic [9:0]  quoted_sum;
	logic [23:0] cmd_word;
	logic [7:0]  station_address;

	fcr_pkg::result_t pending_results [$];
	fcr_pkg::result_t burst [7];
	int          burst_len;

	int unsigned mismatches = 0;
	int unsigned sent_words = 0;
	int unsigned rx_gap_max = 0;
	int unsigned result_stall_max = 0;

	always #1 clk = ~clk;

	function automatic int unsigned set_bits(input logic [7:0] v);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 8; i++) n += v[i];
		return n;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= fcr_pkg::ASCII_ZERO) && (c <= fcr_pkg::ASCII_NINE);
	endfunction

	function automatic logic [7:0] non_digit();
		if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 8'h2F));
		return 8'($urandom_range(8'h3A, 8'hFE));
	endfunction

	function automatic int unsigned idle_limit();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 19;
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: %s", $time, what);
	endtask

	task automatic add_word(input logic [1:0] kind, input logic [7:0] tx, input logic [23:0] cmd);
		burst[burst_len] = {kind, tx, cmd, 1'b0};
		burst_len++;
	endtask

	task automatic add_ack(input logic [7:0] code);
		add_word(fcr_pkg::KIND_TX, fcr_pkg::START_BYTE, 24'h0);
		add_word(fcr_pkg::KIND_TX, fcr_pkg::START_BYTE, 24'h0);
		add_word(fcr_pkg::KIND_TX, code, 24'h0);
	endtask

	task automatic open_checksum();
		char_count = 2'd0;
		digits_closed = 1'b0;
		quoted_sum = 10'd0;
		parse_phase = fcr_pkg::PH_CSUM;
	endtask

	// Advances the mirrored parser by one accepted word and queues the words it answers with.
	task automatic predict_response(input logic [7:0] b);
		burst_len = 0;
		if (b != fcr_pkg::SKIP_BYTE) begin
			case (parse_phase)
				fcr_pkg::PH_HUNT: begin
					if (b == fcr_pkg::STOP_BYTE) begin
						add_word(fcr_pkg::KIND_STOP, 8'h00, 24'h0);
					end else if (b == fcr_pkg::START_BYTE) begin
						ones_total = 10'd0;
						char_count = 2'd0;
						digits_closed = 1'b0;
						frame_length = 7'd0;
						parse_phase = fcr_pkg::PH_LEN;
					end
				end
				fcr_pkg::PH_LEN: begin
					if (!digits_closed) begin
						if (is_digit(b))
							frame_length = 7'(frame_length * 10 + (b - fcr_pkg::ASCII_ZERO));
						else digits_closed = 1'b1;
					end
					char_count = char_count + 2'd1;
					if (char_count >= 2'd2) begin
						args_remaining = (frame_length > 7'd4) ? frame_length - 7'd4 : 7'd0;
						parse_phase = fcr_pkg::PH_ADDR;
					end
				end
				fcr_pkg::PH_ADDR: begin
					ones_total = 10'(set_bits(b));
					if (b != station_address) begin
						add_ack(fcr_pkg::ASCII_ONE);
						parse_phase = fcr_pkg::PH_HUNT;
					end else begin
						char_count = 2'd0;
						cmd_word = 24'h0;
						parse_phase = fcr_pkg::PH_CMD;
					end
				end
				fcr_pkg::PH_CMD: begin
					cmd_word = {cmd_word[15:0], b};
					ones_total = 10'(ones_total + set_bits(b));
					char_count = char_count + 2'd1;
					if (char_count >= 2'd3) begin
						if (args_remaining != 7'd0) parse_phase = fcr_pkg::PH_ARGS;
						else open_checksum();
					end
				end
				fcr_pkg::PH_ARGS: begin
					ones_total = 10'(ones_total + set_bits(b));
					if (args_remaining != 7'd0) args_remaining = args_remaining - 7'd1;
					if (args_remaining == 7'd0) open_checksum();
				end
				fcr_pkg::PH_CSUM: begin
					if (!digits_closed) begin
						if (is_digit(b))
							quoted_sum = 10'(quoted_sum * 10 + (b - fcr_pkg::ASCII_ZERO));
						else digits_closed = 1'b1;
					end
					char_count = char_count + 2'd1;
					if (char_count >= 2'd3) begin
						if (ones_total != quoted_sum) begin
							add_ack(fcr_pkg::ASCII_ZERO);
						end else begin
							add_ack(fcr_pkg::ASCII_ONE);
							add_ack(fcr_pkg::ASCII_ONE);
							add_word(fcr_pkg::KIND_ACCEPT, 8'h00, cmd_word);
						end
						parse_phase = fcr_pkg::PH_HUNT;
					end
				end
			endcase
		end
		for (int k = 0; k < burst_len; k++) begin
			burst[k].last_of_run = (k == burst_len - 1);
			pending_results.push_back(burst[k]);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = $urandom_range(0, rx_gap_max);
		repeat (gap) begin
			@(negedge clk);
			rx.valid <= 1'b0;
		end
		@(negedge clk);
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (rx.ready !== 1'b1);
		predict_response(b);
		if (b != fcr_pkg::SKIP_BYTE) sent_words++;
	endtask

	task automatic send_sequence(input byte_seq_t seq);
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	// Within a frame a timeout word now and then must leave the parse untouched.
	task automatic send_frame_byte(input logic [7:0] b);
		if ($urandom_range(0, 19) == 0) send_byte(fcr_pkg::SKIP_BYTE);
		send_byte(b);
	endtask

	task automatic drain_all();
		@(negedge clk);
		rx.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_station_address(input logic [7:0] a);
		drain_all();
		@(negedge clk);
		wr_en <= 1'b1;
		wr_data <= a;
		@(negedge clk);
		wr_en <= 1'b0;
		station_address = a;
	endtask

	task automatic send_random_frame(input int unsigned nargs);
		logic [7:0]  body [$];
		logic [7:0]  addr;
		int unsigned style;
		int unsigned len;
		int unsigned csum;
		style = $urandom_range(0, 19);
		if (style <= 1) nargs = 0;
		len = (style == 1) ? $urandom_range(0, 3) : nargs + 4;
		addr = ($urandom_range(0, 6) != 0) ? station_address : 8'($urandom_range(0, 254));
		body.push_back(addr);
		repeat (3 + nargs) body.push_back(8'($urandom_range(0, 254)));
		csum = 0;
		foreach (body[i]) csum += set_bits(body[i]);

		send_frame_byte(fcr_pkg::START_BYTE);
		if (style == 0) begin
			// A length that opens with a non-digit reads as zero.
			send_frame_byte(non_digit());
			send_frame_byte(8'($urandom_range(0, 254)));
		end else begin
			send_frame_byte(8'(fcr_pkg::ASCII_ZERO + len / 10));
			send_frame_byte(8'(fcr_pkg::ASCII_ZERO + len % 10));
		end
		foreach (body[i]) send_frame_byte(body[i]);
		if ($urandom_range(0, 39) == 0) drain_all();

		style = $urandom_range(0, 19);
		if (style == 15 || style == 16 || style == 18) csum = (csum + $urandom_range(1, 9)) % 1000;
		if (style == 19) begin
			repeat (3) send_frame_byte(8'($urandom_range(0, 254)));
		end else if (style >= 17 && csum < 100) begin
			send_frame_byte(8'(fcr_pkg::ASCII_ZERO + csum / 10));
			send_frame_byte(8'(fcr_pkg::ASCII_ZERO + csum % 10));
			send_frame_byte(non_digit());
		end else begin
			send_frame_byte(8'(fcr_pkg::ASCII_ZERO + csum / 100));
			send_frame_byte(8'(fcr_pkg::ASCII_ZERO + (csum / 10) % 10));
			send_frame_byte(8'(fcr_pkg::ASCII_ZERO + csum % 10));
		end
	endtask

	task automatic test_hunting();
		rx_gap_max = 0;
		result_stall_max = 0;
		send_sequence('{fcr_pkg::STOP_BYTE, fcr_pkg::SKIP_BYTE, 8'h41, 8'h00,
			fcr_pkg::STOP_BYTE});
	endtask

	task automatic test_address_mismatch();
		rx_gap_max = 3;
		result_stall_max = 19;
		send_sequence('{fcr_pkg::START_BYTE, "0", "4", 8'h4D});
	endtask

	task automatic test_accepted_frame();
		rx_gap_max = 19;
		result_stall_max = 3;
		// A stop byte inside a frame is plain command data.
		send_sequence('{fcr_pkg::START_BYTE, "0", "5", 8'h4C, fcr_pkg::STOP_BYTE,
			fcr_pkg::SKIP_BYTE, 8'h00, 8'hFE});
		drain_all();
		send_sequence('{8'h80, "0", "1", "3"});
	endtask

	task automatic test_checksum_mismatch();
		rx_gap_max = 0;
		result_stall_max = 19;
		send_sequence('{fcr_pkg::START_BYTE, "+", "9", 8'h4C, 8'h00, 8'h01, 8'h02,
			"4", " ", "9"});
	endtask

	task automatic test_random_traffic();
		int unsigned stop_at;
		int unsigned segment_end;
		int          segment;
		logic [7:0]  addr;
		int unsigned r;
		stop_at = sent_words + RANDOM_WORDS;
		segment = 0;
		rx_gap_max = idle_limit();
		result_stall_max = idle_limit();
		send_random_frame(95);
		while (sent_words < stop_at) begin
			case (segment)
				0: addr = 8'h00;
				1: addr = 8'hFF;
				default: addr = ($urandom_range(0, 3) == 0) ? fcr_pkg::OWN_ADDRESS_RESET
					: 8'($urandom_range(0, 254));
			endcase
			set_station_address(addr);
			rx_gap_max = idle_limit();
			result_stall_max = idle_limit();
			segment_end = sent_words + 60;
			while (sent_words < segment_end && sent_words < stop_at) begin
				repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
				r = $urandom_range(0, 19);
				if (r < 17) send_random_frame($urandom_range(0, 6));
				else if (r < 19) send_random_frame($urandom_range(7, 20));
				else send_random_frame($urandom_range(21, 95));
			end
			segment++;
		end
	endtask

	initial begin : drive_result_ready
		int unsigned stall;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, result_stall_max);
			repeat (stall) begin
				@(negedge clk);
				result.ready <= 1'b0;
			end
			@(negedge clk);
			result.ready <= 1'b1;
			do @(posedge clk); while (result.valid !== 1'b1);
		end
	end

	always @(posedge clk) begin : check_words
		fcr_pkg::result_t got;
		fcr_pkg::result_t want;
		if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
			got = {result.out_kind, result.tx_byte, result.frame_command, result.last_of_run};
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind %0d tx %02h cmd %06h last %0d",
					got.out_kind, got.tx_byte, got.frame_command, got.last_of_run));
			end else begin
				want = pending_results.pop_front();
				if (got.out_kind !== want.out_kind || got.tx_byte !== want.tx_byte ||
						got.frame_command !== want.frame_command ||
						got.last_of_run !== want.last_of_run) begin
					report_mismatch($sformatf(
						"got kind %0d tx %02h cmd %06h last %0d, wanted %0d %02h %06h %0d",
						got.out_kind, got.tx_byte, got.frame_command, got.last_of_run,
						want.out_kind, want.tx_byte, want.frame_command, want.last_of_run));
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_data = 8'h00;
		rx.valid = 1'b0;
		rx.rx_byte = 8'h00;
		station_address = fcr_pkg::OWN_ADDRESS_RESET;
		parse_phase = fcr_pkg::PH_HUNT;
		char_count = 2'd0;
		digits_closed = 1'b0;
		frame_length = 7'd0;
		args_remaining = 7'd0;
		ones_total = 10'd0;
		quoted_sum = 10'd0;
		cmd_word = 24'h0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_hunting();
		test_address_mismatch();
		test_accepted_frame();
		test_checksum_mismatch();
		test_random_traffic();

		drain_all();
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/fcr_pkg.sv
src/fcr_byte_if.sv
src/fcr_result_if.sv
src/fcr_front.sv
src/fcr_queue.sv
src/fcr_back.sv
src/framed_command_receiver_unit.sv
tb/framed_command_receiver_unit_test.sv
